// ===== rtl/cmpl_pkg.sv =====
// Shared types and codes for the compacting ordered list.
package cmpl_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET    = 3'd2,
    OP_READ   = 3'd3,
    OP_SWAP   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } st_e;

  typedef struct packed {
    st_e         status;
    logic [31:0] read_value;
    logic [7:0]  removed_position;
    logic [8:0]  entry_count;
    logic        is_empty;
  } res_t;

endpackage

// ===== rtl/cmpl_core.sv =====
// Sequencer and entry memory of the compacting ordered list.
module cmpl_core #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [2:0]       opcode_i,
  input  logic [7:0]       index_a_i,
  input  logic [7:0]       index_b_i,
  input  logic [31:0]      value_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output cmpl_pkg::res_t   res_o
);
  import cmpl_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [2:0]             op_q;
  logic [7:0]             ia_q;
  logic [7:0]             ib_q;
  logic [WORD_BITS-1:0]   word_q;
  logic [WORD_BITS-1:0]   tmp_q;
  logic [WORD_BITS-1:0]   rdval_q;
  logic [CW-1:0]          count_q;
  logic [AW-1:0]          idx_q;
  logic [AW-1:0]          pos_q;
  st_e                    status_q;

  logic [WORD_BITS-1:0]   mem [DEPTH];
  logic [WORD_BITS-1:0]   rdata_q;

  logic [AW-1:0]          raddr;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [WORD_BITS-1:0]   wdata;

  logic [63:0]            val_ext;
  logic [63:0]            rd_ext;
  logic [31:0]            pos_ext;
  logic [31:0]            cnt_ext;
  logic                   ia_ok;
  logic                   ib_ok;
  logic                   full;
  logic                   hit;
  logic [CW-1:0]          idx_p1;
  logic [CW-1:0]          idx_p2;

  assign val_ext = 64'(value_i);
  assign rd_ext  = 64'(rdval_q);
  assign pos_ext = 32'(pos_q);
  assign cnt_ext = 32'(count_q);
  assign ia_ok   = 32'(ia_q) < cnt_ext;
  assign ib_ok   = 32'(ib_q) < cnt_ext;
  assign full    = cnt_ext >= DEPTH;
  assign hit     = rdata_q == word_q;
  assign idx_p1  = CW'(idx_q) + CW'(1);
  assign idx_p2  = CW'(idx_q) + CW'(2);

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = word_q;
    case (state_q)
      S_EXEC: begin
        case (op_q)
          OP_PUSH: begin
            we    = !full;
            waddr = AW'(count_q);
          end
          OP_SET: begin
            we    = ia_ok;
            waddr = AW'(ia_q);
          end
          OP_READ, OP_SWAP: raddr = AW'(ia_q);
          default: raddr = '0;
        endcase
      end
      S_SW_A: raddr = AW'(ib_q);
      S_SW_B: begin
        we    = 1'b1;
        waddr = AW'(ia_q);
        wdata = rdata_q;
      end
      S_SW_C: begin
        we    = 1'b1;
        waddr = AW'(ib_q);
        wdata = tmp_q;
      end
      S_SEARCH: raddr = AW'(idx_p1);
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata_q;
        raddr = AW'(idx_p2);
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= '0;
      ia_q     <= '0;
      ib_q     <= '0;
      word_q   <= '0;
      tmp_q    <= '0;
      rdval_q  <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      status_q <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            op_q    <= opcode_i;
            ia_q    <= index_a_i;
            ib_q    <= index_b_i;
            word_q  <= val_ext[WORD_BITS-1:0];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_q <= ST_OK;
          rdval_q  <= '0;
          pos_q    <= '0;
          idx_q    <= '0;
          state_q  <= S_DONE;
          case (op_q)
            OP_PUSH: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                count_q <= count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                status_q <= ST_NOT_FOUND;
              end else begin
                state_q <= S_SEARCH;
              end
            end
            OP_SET: begin
              if (!ia_ok) begin
                status_q <= ST_RANGE;
              end
            end
            OP_READ: begin
              if (!ia_ok) begin
                status_q <= ST_RANGE;
              end else begin
                state_q <= S_RD_WAIT;
              end
            end
            OP_SWAP: begin
              if (!(ia_ok && ib_ok)) begin
                status_q <= ST_RANGE;
              end else begin
                state_q <= S_SW_A;
              end
            end
            OP_CLEAR: count_q <= '0;
            default: status_q <= ST_OK;
          endcase
        end
        S_RD_WAIT: begin
          rdval_q <= rdata_q;
          state_q <= S_DONE;
        end
        S_SW_A: begin
          tmp_q   <= rdata_q;
          state_q <= S_SW_B;
        end
        S_SW_B: state_q <= S_SW_C;
        S_SW_C: state_q <= S_DONE;
        S_SEARCH: begin
          if (hit) begin
            pos_q <= idx_q;
            if (idx_p1 < count_q) begin
              state_q <= S_SHIFT;
            end else begin
              count_q <= count_q - CW'(1);
              state_q <= S_DONE;
            end
          end else if (idx_p1 < count_q) begin
            idx_q <= AW'(idx_p1);
          end else begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (idx_p2 < count_q) begin
            idx_q <= AW'(idx_p1);
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_ready_o            = state_q == S_IDLE;
  assign res_valid_o            = state_q == S_DONE;
  assign res_o.status           = status_q;
  assign res_o.read_value       = rd_ext[31:0];
  assign res_o.removed_position = pos_ext[7:0];
  assign res_o.entry_count      = cnt_ext[8:0];
  assign res_o.is_empty         = count_q == '0;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= DEPTH)
    else $error("entry count above depth");

  a_search_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (32'(idx_q) < cnt_ext))
    else $error("search index beyond count");

  a_shift_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (32'(idx_q) + 32'd1 < cnt_ext))
    else $error("shift source beyond count");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("count moved without a request");

endmodule

// ===== rtl/compacting_ordered_list.sv =====
// Top level of the compacting ordered list: request sequencer plus result register.
//
//  channel | valid/ready             | payload
//  --------+-------------------------+------------------------------------------------
//  in      | in_valid_i / in_ready_o | opcode_i index_a_i index_b_i value_i
//  out     | out_valid_o/out_ready_i | status_o read_value_o removed_position_o
//          |                         | entry_count_o is_empty_o
//
//  Push, set, clear and unused opcodes pass through the execute state alone; read adds a
//  read-wait state, swap the swap states, remove a search step per entry searched and a
//  shift step per entry shifted down; the single read port and single write port of the
//  entry memory set this. One request is in work at a time; the next is taken once the result
//  enters the output register. Reset clears the registers, not the entry memory.
module compacting_ordered_list #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  index_a_i,
  input  logic [7:0]  index_b_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [7:0]  removed_position_o,
  output logic [8:0]  entry_count_o,
  output logic        is_empty_o
);
  import cmpl_pkg::*;

  logic  res_valid;
  logic  res_ready;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;

  cmpl_core #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .opcode_i    (opcode_i),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign read_value_o       = out_q.read_value;
  assign removed_position_o = out_q.removed_position;
  assign entry_count_o      = out_q.entry_count;
  assign is_empty_o         = out_q.is_empty;

endmodule
